/* hdl/urad_pkg.sv */
// urad_pkg: shared constants, controller/datapath command and status types,
// and the digit-to-ASCII glyph function for the radix ASCII converter.
// No dependencies.
package urad_pkg;

    // Fixed field widths of the channels
    localparam int VALUE_BITS  = 32;
    localparam int RADIX_BITS  = 6;
    localparam int CHAR_BITS   = 8;
    localparam int DIGIT_BITS  = 6;

    // Default parameter values
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;
    localparam int RADIX_MAX_DEF   = 36;

    // Smallest legal radix; anything below is an error transaction
    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;

    // Glyph set boundaries
    localparam logic [DIGIT_BITS-1:0] DIGIT_TOP    = 6'd35;
    localparam logic [DIGIT_BITS-1:0] DECIMAL_TOP  = 6'd9;
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0]  CHAR_ALPHA   = 8'h61;
    localparam logic [CHAR_BITS-1:0]  CHAR_NONE    = 8'h00;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture value and radix of a new transaction
        logic step;      // one restoring-division bit step
        logic wr_rem;    // store remainder as next digit, clear remainder
        logic wr_zero;   // store digit zero (value was zero)
        logic rd;        // read digit store into read register
        logic out_load;  // load output payload register
        logic out_last;  // last flag for loaded payload
        logic out_err;   // error payload (character 0)
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic q_zero;    // quotient register is zero
        logic rad_err;   // captured radix is below the minimum
    } t_stat;

    // Digit 0..35 to '0'-'9','a'-'z'; out-of-range digits map to 'z'
    function automatic logic [CHAR_BITS-1:0] glyph(input logic [DIGIT_BITS-1:0] d);
        logic [DIGIT_BITS-1:0] dc;
        dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
        if (dc <= DECIMAL_TOP) begin
            return CHAR_ZERO + {2'b00, dc};
        end
        return CHAR_ALPHA + {2'b00, dc} - 8'd10;
    endfunction

endpackage

/* hdl/urad_in_if.sv */
// urad_in_if: input channel (value, radix) with valid/ready handshake.
// Depends on urad_pkg for field widths.
interface urad_in_if;
    logic                            valid;
    logic                            ready;
    logic [urad_pkg::VALUE_BITS-1:0] value;
    logic [urad_pkg::RADIX_BITS-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

/* hdl/urad_out_if.sv */
// urad_out_if: result channel (character, last, error) with valid/ready.
// Depends on urad_pkg for field widths.
interface urad_out_if;
    logic                           valid;
    logic                           ready;
    logic [urad_pkg::CHAR_BITS-1:0] character;
    logic                           last;
    logic                           error;

    modport source (output valid, output character, output last, output error, input ready);
    modport sink   (input valid, input character, input last, input error, output ready);
endinterface

/* hdl/urad_ctrl.sv */
// urad_ctrl: sequencing state machine for the radix converter. Drives the
// datapath through urad_pkg::t_cmd and watches urad_pkg::t_stat.
module urad_ctrl #(
    parameter int VALUE_WIDTH = urad_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = urad_pkg::MAX_DIGITS_DEF,
    localparam int BW = $clog2(VALUE_WIDTH),
    localparam int CW = $clog2(MAX_DIGITS + 1),
    localparam int AW = $clog2(MAX_DIGITS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  urad_pkg::t_stat i_stat,
    output urad_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]   o_addr
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHK, S_DIV, S_WRITE, S_RD, S_EMIT, S_ERR
    } t_state;

    t_state        r_state;
    logic [BW-1:0] r_bit;
    logic [CW-1:0] r_count;   // digits produced by the current conversion
    logic [AW-1:0] r_idx;     // digit being emitted, counts down
    logic          r_out_valid;
    logic          out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Command decode
    always_comb begin
        o_cmd  = '0;
        o_addr = r_idx;
        unique case (r_state)
            S_IDLE:  o_cmd.load = i_in_valid;
            S_CHK: begin
                if (!i_stat.rad_err && i_stat.q_zero) begin
                    o_cmd.wr_zero = 1'b1;
                    o_addr        = '0;
                end
            end
            S_DIV:   o_cmd.step = 1'b1;
            S_WRITE: begin
                o_cmd.wr_rem = 1'b1;
                o_addr       = r_count[AW-1:0];
            end
            S_RD:    o_cmd.rd = 1'b1;
            S_EMIT: begin
                o_cmd.out_load = out_free;
                o_cmd.out_last = (r_idx == '0);
            end
            S_ERR: begin
                o_cmd.out_load = out_free;
                o_cmd.out_last = 1'b1;
                o_cmd.out_err  = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (i_stat.rad_err) begin
                        r_state <= S_ERR;
                    end else if (i_stat.q_zero) begin
                        r_count <= CW'(1);
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_count <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == BW'(VALUE_WIDTH - 1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_count <= r_count + 1'b1;
                    r_idx   <= r_count[AW-1:0];
                    if (i_stat.q_zero || (r_count == CW'(MAX_DIGITS - 1))) begin
                        r_state <= S_RD;
                    end else begin
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_RD: r_state <= S_EMIT;
                S_EMIT: begin
                    if (out_free) begin
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/urad_dpath.sv */
// urad_dpath: bit-serial restoring divider, digit store and output payload
// register of the radix converter. Uses urad_pkg types and glyph function.
module urad_dpath #(
    parameter int VALUE_WIDTH = urad_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = urad_pkg::MAX_DIGITS_DEF,
    parameter int RADIX_MAX   = urad_pkg::RADIX_MAX_DEF,
    localparam int AW = $clog2(MAX_DIGITS)
) (
    input  logic                            i_clk,
    input  urad_pkg::t_cmd                  i_cmd,
    input  logic [AW-1:0]                   i_addr,
    input  logic [urad_pkg::VALUE_BITS-1:0] i_value,
    input  logic [urad_pkg::RADIX_BITS-1:0] i_radix,
    output urad_pkg::t_stat                 o_stat,
    output logic [urad_pkg::CHAR_BITS-1:0]  o_character,
    output logic                            o_last,
    output logic                            o_error
);

    localparam int DB = urad_pkg::DIGIT_BITS;

    logic [VALUE_WIDTH-1:0] r_q;        // dividend shifting out, quotient shifting in
    logic [DB-1:0]          r_rem;
    logic [DB-1:0]          r_rad;
    logic                   r_rad_err;
    logic [DB-1:0]          r_rd_data;
    logic [DB-1:0]          mem [MAX_DIGITS];
    logic [DB:0]            rem_sh;
    logic [DB:0]            rem_sub;
    logic                   ge;

    // One restoring division step
    assign rem_sh  = {r_rem, r_q[VALUE_WIDTH-1]};
    assign ge      = (rem_sh >= {1'b0, r_rad});
    assign rem_sub = rem_sh - {1'b0, r_rad};

    assign o_stat.q_zero  = (r_q == '0);
    assign o_stat.rad_err = r_rad_err;

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q       <= VALUE_WIDTH'(i_value);
            r_rem     <= '0;
            r_rad_err <= (i_radix < urad_pkg::RADIX_MIN);
            r_rad     <= (i_radix > DB'(RADIX_MAX)) ? DB'(RADIX_MAX) : i_radix;
        end else if (i_cmd.step) begin
            r_q   <= {r_q[VALUE_WIDTH-2:0], ge};
            r_rem <= ge ? rem_sub[DB-1:0] : rem_sh[DB-1:0];
        end else if (i_cmd.wr_rem) begin
            r_rem <= '0;
        end
    end

    // Digit store, least significant digit at address zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_rem) begin
            mem[i_addr] <= r_rem;
        end else if (i_cmd.wr_zero) begin
            mem[i_addr] <= '0;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[i_addr];
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_character <= i_cmd.out_err ? urad_pkg::CHAR_NONE : urad_pkg::glyph(r_rd_data);
            o_last      <= i_cmd.out_last;
            o_error     <= i_cmd.out_err;
        end
    end

endmodule

/* hdl/unsigned_to_radix_ascii.sv */
// Converts an unsigned value to ASCII digits in radix 2..RADIX_MAX (larger
// radixes clamp to RADIX_MAX), most significant digit first, '0'-'9' then
// 'a'-'z', with last set on the final character; zero gives a single '0', and
// a radix below 2 gives one transaction with character 0, last and error set.
// One conversion runs at a time. A bit-serial restoring divider produces one
// quotient bit per cycle, each remainder is written to the digit store as a
// digit, and each character is then read from the digit store and emitted
// when the sink is ready. A zero value skips the divider. The final
// character sits in an output register, so the next input transaction is
// accepted while it waits to be taken.
// Depends on urad_pkg, urad_in_if, urad_out_if, urad_ctrl and urad_dpath.
module unsigned_to_radix_ascii #(
    parameter int VALUE_WIDTH = urad_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = urad_pkg::MAX_DIGITS_DEF,
    parameter int RADIX_MAX   = urad_pkg::RADIX_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    urad_in_if.sink           i_in,
    urad_out_if.source        o_out
);

    localparam int AW = $clog2(MAX_DIGITS);

    urad_pkg::t_cmd  cmd;
    urad_pkg::t_stat stat;
    logic [AW-1:0]   addr;

    // Sequencer
    urad_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    // Divider, digit store and output payload
    urad_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS),
        .RADIX_MAX   (RADIX_MAX)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .i_value     (i_in.value),
        .i_radix     (i_in.radix),
        .o_stat      (stat),
        .o_character (o_out.character),
        .o_last      (o_out.last),
        .o_error     (o_out.error)
    );

endmodule

/* hdl/urad_chk.sv */
// urad_chk: port-level assertions for unsigned_to_radix_ascii, attached by
// the bind statement below. Depends on urad_pkg.
module urad_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [urad_pkg::CHAR_BITS-1:0] i_character,
    input logic                           i_last,
    input logic                           i_error
);

    // Error transaction carries a null character and closes the conversion
    a_err_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> (i_character == urad_pkg::CHAR_NONE) && i_last)
        else $error("error transaction with bad payload");

    // Normal characters come from the digit glyph set
    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_error |->
            ((i_character >= 8'h30) && (i_character <= 8'h39)) ||
            ((i_character >= 8'h61) && (i_character <= 8'h7a)))
        else $error("character outside glyph set");

    // No new input while a conversion still has characters to emit
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input ready in the middle of a conversion");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_character) && $stable(i_last) && $stable(i_error))
        else $error("stalled result changed");

endmodule

bind unsigned_to_radix_ascii urad_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_character (o_out.character),
    .i_last      (o_out.last),
    .i_error     (o_out.error)
);
